[hw/rtl/bpug_pkg.sv]
// shared types and constants for the bmp24 pixel unpack and gray block
`timescale 1ns / 1ps
`default_nettype none
package bpug_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_DATA_OFFSET  = 2'd2;

    // field widths fixed by the item format
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int SIZE_REG_W  = 13;
    localparam int OFFSET_W    = 16;
    localparam int COORD_W     = 12;
    localparam int CHAN_W      = 8;

    // register reset values
    localparam logic [SIZE_REG_W-1:0] WIDTH_RESET  = 13'd1;
    localparam logic [SIZE_REG_W-1:0] HEIGHT_RESET = 13'd1;
    localparam logic [OFFSET_W-1:0]   OFFSET_RESET = 16'd54;

    // luma weights and rounding
    localparam logic [7:0] LUMA_R_WT = 8'd77;
    localparam logic [7:0] LUMA_G_WT = 8'd150;
    localparam logic [7:0] LUMA_B_WT = 8'd29;
    localparam logic [15:0] LUMA_ROUND = 16'd128;

    // one decoded pixel handed from parser to output stage
    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [CHAN_W-1:0]  red;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  blue;
        logic               last;
    } pixel_t;

endpackage
`default_nettype wire

[hw/rtl/bpug_cfg_regs.sv]
// configuration registers and effective image size clamping
`timescale 1ns / 1ps
`default_nettype none
module bpug_cfg_regs #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096,
    parameter int WW = $clog2(MAX_WIDTH + 1),
    parameter int HW = $clog2(MAX_HEIGHT + 1)
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [bpug_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [bpug_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic [WW-1:0]                       eff_width,
    output logic [HW-1:0]                       eff_height,
    output logic [bpug_pkg::OFFSET_W-1:0]       offset
);
    import bpug_pkg::*;

    logic [SIZE_REG_W-1:0] image_width_reg;
    logic [SIZE_REG_W-1:0] image_height_reg;
    logic [OFFSET_W-1:0]   data_offset_reg;
    logic [31:0]           width_full;
    logic [31:0]           height_full;

    // register writes, unknown index ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= WIDTH_RESET;
            image_height_reg <= HEIGHT_RESET;
            data_offset_reg  <= OFFSET_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[SIZE_REG_W-1:0];
                CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data[SIZE_REG_W-1:0];
                CFG_DATA_OFFSET:  data_offset_reg  <= cfg_data[OFFSET_W-1:0];
                default:          ;
            endcase
        end
    end

    // zero size reads as one, oversize clamps to the maximum
    always_comb
    begin
        if (image_width_reg == '0)
            width_full = 32'd1;
        else if (32'(image_width_reg) > 32'(MAX_WIDTH))
            width_full = 32'(MAX_WIDTH);
        else
            width_full = 32'(image_width_reg);

        if (image_height_reg == '0)
            height_full = 32'd1;
        else if (32'(image_height_reg) > 32'(MAX_HEIGHT))
            height_full = 32'(MAX_HEIGHT);
        else
            height_full = 32'(image_height_reg);
    end

    assign eff_width  = width_full[WW-1:0];
    assign eff_height = height_full[HW-1:0];
    assign offset     = data_offset_reg;

endmodule
`default_nettype wire

[hw/rtl/bpug_parser.sv]
// byte stream parser: header skip, bgr triples, row padding, pixel coordinates
`timescale 1ns / 1ps
`default_nettype none
module bpug_parser #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096,
    parameter int WW = $clog2(MAX_WIDTH + 1),
    parameter int HW = $clog2(MAX_HEIGHT + 1)
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       accept,
    input  wire logic [7:0]                 data_byte,
    input  wire logic                       file_start,
    input  wire logic [WW-1:0]              eff_width,
    input  wire logic [HW-1:0]              eff_height,
    input  wire logic [bpug_pkg::OFFSET_W-1:0] offset,
    output logic                            pix_valid,
    output bpug_pkg::pixel_t                pix
);
    import bpug_pkg::*;

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    // byte phase codes within a pixel
    localparam logic [1:0] PH_BLUE  = 2'd0;
    localparam logic [1:0] PH_GREEN = 2'd1;
    localparam logic [1:0] PH_RED   = 2'd2;

    logic [OFFSET_W-1:0] skip_count_reg, skip_count_next, skip_cur;
    logic [RW-1:0]       row_count_reg, row_count_next, row_cur;
    logic [CW-1:0]       col_count_reg, col_count_next, col_cur;
    logic [1:0]          byte_phase_reg, byte_phase_next, phase_cur;
    logic [1:0]          pad_left_reg, pad_left_next, pad_cur;
    logic                image_done_reg, image_done_next, done_cur;
    logic [CHAN_W-1:0]   saved_blue_reg, saved_blue_next;
    logic [CHAN_W-1:0]   saved_green_reg, saved_green_next;
    logic [31:0]         row_flip;
    logic [31:0]         col_wide;
    logic                row_end;
    logic                img_end;
    logic                pixel_done;

    // a start flag makes this byte file position zero
    always_comb
    begin
        skip_cur  = file_start ? '0 : skip_count_reg;
        row_cur   = file_start ? '0 : row_count_reg;
        col_cur   = file_start ? '0 : col_count_reg;
        phase_cur = file_start ? PH_BLUE : byte_phase_reg;
        pad_cur   = file_start ? 2'd0 : pad_left_reg;
        done_cur  = file_start ? 1'b0 : image_done_reg;
    end

    // end of row and end of image tests against the live size
    assign row_end = (32'(col_cur) + 32'd1) >= 32'(eff_width);
    assign img_end = (32'(row_cur) + 32'd1) >= 32'(eff_height);

    // next state for one byte
    always_comb
    begin
        skip_count_next  = skip_cur;
        row_count_next   = row_cur;
        col_count_next   = col_cur;
        byte_phase_next  = phase_cur;
        pad_left_next    = pad_cur;
        image_done_next  = done_cur;
        saved_blue_next  = saved_blue_reg;
        saved_green_next = saved_green_reg;
        pixel_done       = 1'b0;

        if (done_cur)
        begin
            // bytes after the image are dropped
        end
        else if (32'(skip_cur) < 32'(offset))
        begin
            skip_count_next = skip_cur + OFFSET_W'(1);
        end
        else if (pad_cur != 2'd0)
        begin
            pad_left_next = pad_cur - 2'd1;
        end
        else
        begin
            unique case (phase_cur)
                PH_BLUE:
                begin
                    saved_blue_next = data_byte;
                    byte_phase_next = PH_GREEN;
                end
                PH_GREEN:
                begin
                    saved_green_next = data_byte;
                    byte_phase_next  = PH_RED;
                end
                default:
                begin
                    pixel_done      = 1'b1;
                    byte_phase_next = PH_BLUE;
                    if (row_end)
                    begin
                        col_count_next = '0;
                        pad_left_next  = eff_width[1:0];
                        if (img_end)
                            image_done_next = 1'b1;
                        else
                            row_count_next = row_cur + RW'(1);
                    end
                    else
                    begin
                        col_count_next = col_cur + CW'(1);
                    end
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_count_reg <= '0;
            row_count_reg  <= '0;
            col_count_reg  <= '0;
            byte_phase_reg <= PH_BLUE;
            pad_left_reg   <= 2'd0;
            image_done_reg <= 1'b0;
        end
        else if (accept)
        begin
            skip_count_reg <= skip_count_next;
            row_count_reg  <= row_count_next;
            col_count_reg  <= col_count_next;
            byte_phase_reg <= byte_phase_next;
            pad_left_reg   <= pad_left_next;
            image_done_reg <= image_done_next;
        end
    end

    // saved channels, always written before they are read
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            saved_blue_reg  <= saved_blue_next;
            saved_green_reg <= saved_green_next;
        end
    end

    // pixel fields, row flipped to top-down modulo the field width
    assign row_flip = 32'(eff_height) - 32'd1 - 32'(row_cur);
    assign col_wide = 32'(col_cur);

    assign pix_valid = accept && pixel_done;

    always_comb
    begin
        pix.row   = row_flip[COORD_W-1:0];
        pix.col   = col_wide[COORD_W-1:0];
        pix.red   = data_byte;
        pix.green = saved_green_reg;
        pix.blue  = saved_blue_reg;
        pix.last  = row_end && img_end;
    end

    // phase code three is never reached
    assert property (@(posedge clk) disable iff (!rst_n) byte_phase_reg != 2'd3)
        else $error("byte phase out of range");

    // padding only counts down between pixels
    assert property (@(posedge clk) disable iff (!rst_n)
        pad_left_reg != 2'd0 |-> byte_phase_reg == PH_BLUE)
        else $error("padding inside a pixel");

    // a finished image leaves column and phase cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        image_done_reg |-> (col_count_reg == '0 && byte_phase_reg == PH_BLUE))
        else $error("image done with partial state");

    // no pixel after the image until a new start
    assert property (@(posedge clk) disable iff (!rst_n)
        (image_done_reg && !file_start) |-> !pix_valid)
        else $error("pixel after end of image");

endmodule
`default_nettype wire

[hw/rtl/bpug_out_stage.sv]
// luma computation and result register with flow control
`timescale 1ns / 1ps
`default_nettype none
module bpug_out_stage (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          pix_valid,
    input  wire bpug_pkg::pixel_t              pix,
    output logic                               take_ready,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [bpug_pkg::COORD_W-1:0]       pixel_row,
    output logic [bpug_pkg::COORD_W-1:0]       pixel_col,
    output logic [bpug_pkg::CHAN_W-1:0]        red,
    output logic [bpug_pkg::CHAN_W-1:0]        green,
    output logic [bpug_pkg::CHAN_W-1:0]        blue,
    output logic [bpug_pkg::CHAN_W-1:0]        gray,
    output logic                               last_pixel
);
    import bpug_pkg::*;

    logic              out_valid_reg, out_valid_next;
    pixel_t            pix_reg;
    logic [CHAN_W-1:0] gray_reg;
    logic [15:0]       luma_sum;

    // weighted sum with rounding, fits 16 bits
    assign luma_sum = 16'(pix.red)   * 16'(LUMA_R_WT)
                    + 16'(pix.green) * 16'(LUMA_G_WT)
                    + 16'(pix.blue)  * 16'(LUMA_B_WT)
                    + LUMA_ROUND;

    // slot is free when empty or being drained this cycle
    assign take_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pix_valid)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (pix_valid)
        begin
            pix_reg  <= pix;
            gray_reg <= luma_sum[15:8];
        end
    end

    assign out_valid  = out_valid_reg;
    assign pixel_row  = pix_reg.row;
    assign pixel_col  = pix_reg.col;
    assign red        = pix_reg.red;
    assign green      = pix_reg.green;
    assign blue       = pix_reg.blue;
    assign gray       = gray_reg;
    assign last_pixel = pix_reg.last;

endmodule
`default_nettype wire

[hw/rtl/bmp24_pixel_unpack_gray_top.sv]
// top level of the bmp24 pixel unpack and gray block
// a result item is registered and valid in the cycle after its red byte is accepted
// throughput: one byte item per cycle while the output register is empty or out_ready is high
// a result waiting in the output register still lets the next byte in when out_ready is high
// reset: asynchronous active low, counters cleared as after a start flag
// reset loads image width 1, image height 1, data offset 54
`timescale 1ns / 1ps
`default_nettype none
module bmp24_pixel_unpack_gray_top #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [bpug_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [bpug_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [7:0]                      data_byte,
    input  wire logic                            file_start,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [bpug_pkg::COORD_W-1:0]         pixel_row,
    output logic [bpug_pkg::COORD_W-1:0]         pixel_col,
    output logic [bpug_pkg::CHAN_W-1:0]          red,
    output logic [bpug_pkg::CHAN_W-1:0]          green,
    output logic [bpug_pkg::CHAN_W-1:0]          blue,
    output logic [bpug_pkg::CHAN_W-1:0]          gray,
    output logic                                 last_pixel
);
    import bpug_pkg::*;

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    logic [WW-1:0]       eff_width;
    logic [HW-1:0]       eff_height;
    logic [OFFSET_W-1:0] offset;
    logic                accept;
    logic                pix_valid;
    pixel_t              pix;

    assign accept = in_valid && in_ready;

    // configuration registers
    bpug_cfg_regs #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .WW         (WW),
        .HW         (HW)
    ) u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .eff_width  (eff_width),
        .eff_height (eff_height),
        .offset     (offset)
    );

    // byte parser
    bpug_parser #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .WW         (WW),
        .HW         (HW)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .data_byte  (data_byte),
        .file_start (file_start),
        .eff_width  (eff_width),
        .eff_height (eff_height),
        .offset     (offset),
        .pix_valid  (pix_valid),
        .pix        (pix)
    );

    // luma and result register
    bpug_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix_valid  (pix_valid),
        .pix        (pix),
        .take_ready (in_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pixel_row  (pixel_row),
        .pixel_col  (pixel_col),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .gray       (gray),
        .last_pixel (last_pixel)
    );

endmodule
`default_nettype wire
